// ----- design/fapk_pkg.sv -----
// Shared types, constants and float-to-fixed helpers for the ARGB color packer.
package fapk_pkg;

	// Q1.24 fixed point: 1.0 is 2^24, values run 0 .. 2^24
	localparam int QW = 25;
	localparam logic [QW-1:0] Q_ONE = QW'(1) << 24;

	// IEEE single field limits
	localparam logic [7:0] EXP_ONE = 8'd127;
	localparam logic [7:0] EXP_MAX = 8'hff;
	localparam logic [7:0] SHIFT_BASE = 8'd126;

	// opcodes
	typedef enum logic {
		OP_FLOAT = 1'b0,
		OP_INTENSITY = 1'b1
	} fapk_op_t;

	// advance enables for the three pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} fapk_stage_en_t;

	// Clamp a single-precision pattern to [0,1] and truncate to Q1.24.
	// NaN, negatives, zero and subnormals give 0; 1.0 and above give 1.0.
	function automatic logic [QW-1:0] to_q24(input logic [31:0] w);
		logic [7:0] expo;
		logic [22:0] frac;
		logic [7:0] shift;
		logic [23:0] mant;
		logic [QW-1:0] res;
		expo = w[30:23];
		frac = w[22:0];
		shift = SHIFT_BASE - expo;
		mant = {1'b1, frac};
		if (expo == EXP_MAX && frac != 23'd0) begin
			res = '0;
		end else if (w[31]) begin
			res = '0;
		end else if (expo >= EXP_ONE) begin
			res = Q_ONE;
		end else if (expo == 8'd0) begin
			res = '0;
		end else if (shift >= 8'd24) begin
			res = '0;
		end else begin
			res = QW'(mant >> shift[4:0]);
		end
		return res;
	endfunction

	// floor(q * 255 / 2^24), saturated at 255
	function automatic logic [7:0] q24_to_byte(input logic [QW-1:0] q);
		logic [QW+7:0] prod;
		logic [8:0] v;
		prod = {q, 8'd0} - {8'd0, q};
		v = prod[QW+7:24];
		return (v > 9'd255) ? 8'hff : v[7:0];
	endfunction

endpackage

// ----- design/fapk_lane.sv -----
// One color lane: float to Q1.24, scale by intensity, then to a byte.
module fapk_lane (
	input  logic                       clk,
	input  fapk_pkg::fapk_stage_en_t   en,
	input  logic [31:0]                chan_bits,
	input  logic [fapk_pkg::QW-1:0]    scale_s1,
	output logic [7:0]                 byte_s3
);

	logic [fapk_pkg::QW-1:0] q_s1;
	logic [fapk_pkg::QW-1:0] scaled_s2;
	logic [2*fapk_pkg::QW-1:0] prod;

	// stage 1: clamp and convert
	always_ff @(posedge clk) begin
		if (en.s1) begin
			q_s1 <= fapk_pkg::to_q24(chan_bits);
		end
	end

	// stage 2: scale and truncate back to Q1.24
	assign prod = q_s1 * scale_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			scaled_s2 <= prod[fapk_pkg::QW+23:24];
		end
	end

	// stage 3: byte conversion
	always_ff @(posedge clk) begin
		if (en.s3) begin
			byte_s3 <= fapk_pkg::q24_to_byte(scaled_s2);
		end
	end

endmodule

// ----- design/float_argb_color_packer_core.sv -----
// Top level of the float ARGB8888 color packer: four lanes and the merge.
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+-----
//  input   | in_valid, in_ready, opcode, alpha/red/green/blue/  | in
//          | intensity_bits                                    |
//  output  | out_valid, out_ready, argb_word                   | out
//
// Three stages (convert, scale multiply, byte); one request per cycle while
// the output is not stalled. The multiply in each lane sets the stage length.
// Reset clears only the stage valid bits. Each stage advances when the one
// after it is empty or moving, so bubbles close up while the output stalls.
module float_argb_color_packer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] alpha_bits,
	input  logic [31:0] red_bits,
	input  logic [31:0] green_bits,
	input  logic [31:0] blue_bits,
	input  logic [31:0] intensity_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] argb_word
);

	fapk_pkg::fapk_stage_en_t en;
	logic v_s1, v_s2, v_s3;
	logic [fapk_pkg::QW-1:0] scale_s1;
	logic [7:0] a_s3, r_s3, g_s3, b_s3;

	// stage enables, back to front
	always_comb begin
		en.s3 = !v_s3 || out_ready;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end
	assign in_ready = en.s1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
		end
	end

	// RGB scale: intensity in intensity mode, else exactly 1.0
	always_ff @(posedge clk) begin
		if (en.s1) begin
			unique case (fapk_pkg::fapk_op_t'(opcode))
				fapk_pkg::OP_INTENSITY: scale_s1 <= fapk_pkg::to_q24(intensity_bits);
				fapk_pkg::OP_FLOAT:     scale_s1 <= fapk_pkg::Q_ONE;
				default:                scale_s1 <= fapk_pkg::Q_ONE;
			endcase
		end
	end

	// lanes
	fapk_lane u_lane_a (
		.clk(clk), .en(en), .chan_bits(alpha_bits),
		.scale_s1(fapk_pkg::Q_ONE), .byte_s3(a_s3)
	);
	fapk_lane u_lane_r (
		.clk(clk), .en(en), .chan_bits(red_bits),
		.scale_s1(scale_s1), .byte_s3(r_s3)
	);
	fapk_lane u_lane_g (
		.clk(clk), .en(en), .chan_bits(green_bits),
		.scale_s1(scale_s1), .byte_s3(g_s3)
	);
	fapk_lane u_lane_b (
		.clk(clk), .en(en), .chan_bits(blue_bits),
		.scale_s1(scale_s1), .byte_s3(b_s3)
	);

	// merge
	assign argb_word = {a_s3, r_s3, g_s3, b_s3};
	assign out_valid = v_s3;

endmodule

// ----- design/fapk_checker.sv -----
// Port-level checks for the color packer, bound to the top level.
module fapk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] argb_word
);

	// no result shows while reset is asserted
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(argb_word))
		else $error("stalled result changed");

	// a draining output never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// an idle input with the output open empties the pipeline, stage by stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(!in_valid && out_ready) ##1 (!in_valid && out_ready) ##1
		(!in_valid && out_ready) |=> !out_valid)
		else $error("result appeared without a request");

endmodule

bind float_argb_color_packer_core fapk_checker u_fapk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.argb_word(argb_word)
);
